// File: hw/rtl/tsnb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsnb_pkg
// Shared types and constants of the nearest/bilinear texture sampler.
// ----------------------------------------------------------------------------
package tsnb_pkg;

  // Field widths fixed by the interface
  localparam int PIX_COORD_W = 6;
  localparam int PIXEL_W     = 32;
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 7;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 4;
  localparam int CFG_IDX_W   = 1;

  // Product of a Q0.16 coordinate and an image size
  localparam int POS_W = COORD_W + SIZE_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Input item action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Sample mode codes
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Corner of the 2x2 footprint: bit 1 selects the right column, bit 0 the lower row
  typedef enum logic [1:0] {
    CORNER_00 = 2'b00,
    CORNER_01 = 2'b01,
    CORNER_10 = 2'b10,
    CORNER_11 = 2'b11
  } corner_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_READ0,
    ST_READ1,
    ST_READ2,
    ST_READ3,
    ST_LAST,
    ST_NEAR
  } state_t;

  typedef struct packed {
    logic    capture;     // latch sample coordinates
    logic    write;       // store the pixel on the input ports
    logic    calc_idx;    // derive texel indexes and fractions
    logic    wgt_load;    // form the four bilinear weights
    logic    rd_en;
    corner_t rd_corner;
    logic    acc_en;
    logic    acc_clear;
    corner_t acc_corner;  // corner whose texel sits in the read register
    logic    out_near;
    logic    out_bilin;
  } cmd_t;

  typedef struct packed {
    logic bilinear;
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/texture_sampler_nearest_bilinear_top.sv
`default_nettype none
// A write item leaves the sequencer idle; a write may be started every cycle while busy is low.
// Nearest sample: index calculation, one texel read, then the result; the next start may transfer with the result.
// Bilinear sample: index and weight setup plus four sequential reads of the single-port
// pixel store, then the blend; no new item is taken before the sample is through.
// The receiver cannot stall; busy drops in the result strobe cycle.
// Sync reset: sequencer idle, size registers 64x64; the pixel store is not cleared.
// ----------------------------------------------------------------------------
// texture_sampler_nearest_bilinear_top
// RGBA8 texture sampler with nearest and bilinear filtering, wrap addressing.
// ----------------------------------------------------------------------------
module texture_sampler_nearest_bilinear_top #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tsnb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tsnb_pkg::SIZE_W-1:0]      cfg_data,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_action,
  input  wire logic [tsnb_pkg::PIX_COORD_W-1:0] in_pixel_x,
  input  wire logic [tsnb_pkg::PIX_COORD_W-1:0] in_pixel_y,
  input  wire logic [tsnb_pkg::PIXEL_W-1:0]     in_pixel_value,
  input  wire logic [tsnb_pkg::COORD_W-1:0]     in_u_coord,
  input  wire logic [tsnb_pkg::COORD_W-1:0]     in_v_coord,
  input  wire logic                             in_sample_mode,
  output logic                                  out_strobe,
  output logic [tsnb_pkg::CHAN_W-1:0]           out_red,
  output logic [tsnb_pkg::CHAN_W-1:0]           out_green,
  output logic [tsnb_pkg::CHAN_W-1:0]           out_blue,
  output logic [tsnb_pkg::CHAN_W-1:0]           out_alpha
);
  import tsnb_pkg::*;

  cmd_t    cmd;
  status_t status;

  tsnb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  tsnb_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_value (in_pixel_value),
    .in_u_coord     (in_u_coord),
    .in_v_coord     (in_v_coord),
    .in_sample_mode (in_sample_mode),
    .out_strobe     (out_strobe),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha)
  );

endmodule
`default_nettype wire

// File: hw/rtl/tsnb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsnb_ctrl
// Sequencer: accepts commands and steps the datapath through index
// calculation, texel reads and blending.
// ----------------------------------------------------------------------------
module tsnb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             in_action,
  input  wire tsnb_pkg::status_t status,
  output logic                  busy,
  output tsnb_pkg::cmd_t        cmd
);
  import tsnb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_action == ACT_SAMPLE) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_INDEX;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_INDEX: begin
        cmd.calc_idx = 1'b1;
        state_nxt    = ST_READ0;
      end
      ST_READ0: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_corner = CORNER_00;
        cmd.wgt_load  = 1'b1;
        state_nxt     = status.bilinear ? ST_READ1 : ST_NEAR;
      end
      ST_NEAR: begin
        cmd.out_near = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_READ1: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CORNER_01;
        cmd.acc_en     = 1'b1;
        cmd.acc_clear  = 1'b1;
        cmd.acc_corner = CORNER_00;
        state_nxt      = ST_READ2;
      end
      ST_READ2: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CORNER_10;
        cmd.acc_en     = 1'b1;
        cmd.acc_corner = CORNER_01;
        state_nxt      = ST_READ3;
      end
      ST_READ3: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_corner  = CORNER_11;
        cmd.acc_en     = 1'b1;
        cmd.acc_corner = CORNER_10;
        state_nxt      = ST_LAST;
      end
      ST_LAST: begin
        cmd.acc_corner = CORNER_11;
        cmd.out_bilin  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/tsnb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsnb_datapath
// Size registers, coordinate scaling, wrap addressing, single-port pixel
// store and the per-channel weighted accumulator.
// ----------------------------------------------------------------------------
module tsnb_datapath #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tsnb_pkg::cmd_t                       cmd,
  output tsnb_pkg::status_t                         status,
  input  wire logic                                 cfg_we,
  input  wire logic [tsnb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tsnb_pkg::SIZE_W-1:0]          cfg_data,
  input  wire logic [tsnb_pkg::PIX_COORD_W-1:0]     in_pixel_x,
  input  wire logic [tsnb_pkg::PIX_COORD_W-1:0]     in_pixel_y,
  input  wire logic [tsnb_pkg::PIXEL_W-1:0]         in_pixel_value,
  input  wire logic [tsnb_pkg::COORD_W-1:0]         in_u_coord,
  input  wire logic [tsnb_pkg::COORD_W-1:0]         in_v_coord,
  input  wire logic                                 in_sample_mode,
  output logic                                      out_strobe,
  output logic [tsnb_pkg::CHAN_W-1:0]               out_red,
  output logic [tsnb_pkg::CHAN_W-1:0]               out_green,
  output logic [tsnb_pkg::CHAN_W-1:0]               out_blue,
  output logic [tsnb_pkg::CHAN_W-1:0]               out_alpha
);
  import tsnb_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 2 * WEIGHT_BITS + 2;    // weight product width
  localparam int ACCW  = 2 * WEIGHT_BITS + CHAN_W;
  localparam int LIM_W = 11;

  localparam logic [LIM_W-1:0]      MAXW_L    = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0]      MAXH_L    = LIM_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0]     W_RESET   =
    (MAX_WIDTH < 64) ? SIZE_W'(MAX_WIDTH) : SIZE_RESET;
  localparam logic [SIZE_W-1:0]     H_RESET   =
    (MAX_HEIGHT < 64) ? SIZE_W'(MAX_HEIGHT) : SIZE_RESET;
  localparam logic [WEIGHT_BITS:0]  S_ONE     = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
  localparam logic [ACCW-1:0]       ACC_ROUND = ACCW'(1) << (2 * WEIGHT_BITS - 1);
  localparam logic [POS_W:0]        POS_HALF  = (POS_W+1)'(1) << (COORD_W - 1);

  // effective image size, clamped on write
  logic [SIZE_W-1:0] width_r, height_r;
  logic [SIZE_W-1:0] cfg_w_eff, cfg_h_eff;

  always_comb begin
    cfg_w_eff = cfg_data;
    if (cfg_data == '0) begin
      cfg_w_eff = SIZE_W'(1);
    end else if ({{(LIM_W-SIZE_W){1'b0}}, cfg_data} > MAXW_L) begin
      cfg_w_eff = SIZE_W'(MAX_WIDTH);
    end
    cfg_h_eff = cfg_data;
    if (cfg_data == '0) begin
      cfg_h_eff = SIZE_W'(1);
    end else if ({{(LIM_W-SIZE_W){1'b0}}, cfg_data} > MAXH_L) begin
      cfg_h_eff = SIZE_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= W_RESET;
      height_r <= H_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_w_eff;
        CFG_IMAGE_HEIGHT: height_r <= cfg_h_eff;
        default: ;
      endcase
    end
  end

  // coordinate scaling
  logic [POS_W-1:0] pu_r, pv_r;
  logic             mode_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pu_r   <= POS_W'(in_u_coord) * POS_W'(width_r);
      pv_r   <= POS_W'(in_v_coord) * POS_W'(height_r);
      mode_r <= in_sample_mode;
    end
  end

  assign status.bilinear = (mode_r == MODE_BILINEAR);

  // texel indexes with wrap
  logic [POS_W:0]           pu_rnd, pv_rnd;
  logic [CHAN_W-1:0]        xn, yn, xb, yb, xi, yi, xi1, yi1;
  logic [SIZE_W-1:0]        x_r, y_r, x2_r, y2_r;
  logic [WEIGHT_BITS-1:0]   fx_r, fy_r;

  always_comb begin
    pu_rnd = {1'b0, pu_r} + POS_HALF;
    pv_rnd = {1'b0, pv_r} + POS_HALF;
    xn     = pu_rnd[POS_W -: CHAN_W];
    yn     = pv_rnd[POS_W -: CHAN_W];
    xb     = {1'b0, pu_r[POS_W-1 -: SIZE_W]};
    yb     = {1'b0, pv_r[POS_W-1 -: SIZE_W]};
    if (status.bilinear) begin
      xi = xb;
      yi = yb;
    end else begin
      // rounding may land on the size itself
      xi = (xn == {1'b0, width_r})  ? '0 : xn;
      yi = (yn == {1'b0, height_r}) ? '0 : yn;
    end
    xi1 = ((xi + CHAN_W'(1)) == {1'b0, width_r})  ? '0 : xi + CHAN_W'(1);
    yi1 = ((yi + CHAN_W'(1)) == {1'b0, height_r}) ? '0 : yi + CHAN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_idx) begin
      x_r  <= xi[SIZE_W-1:0];
      y_r  <= yi[SIZE_W-1:0];
      x2_r <= xi1[SIZE_W-1:0];
      y2_r <= yi1[SIZE_W-1:0];
      fx_r <= pu_r[COORD_W-1 -: WEIGHT_BITS];
      fy_r <= pv_r[COORD_W-1 -: WEIGHT_BITS];
    end
  end

  // bilinear weights, indexed by corner
  logic [WEIGHT_BITS:0] sfx, sfy;
  logic [WW-1:0]        wgt_r [NUM_CHAN];

  assign sfx = S_ONE - {1'b0, fx_r};
  assign sfy = S_ONE - {1'b0, fy_r};

  always_ff @(posedge clk) begin
    if (cmd.wgt_load) begin
      wgt_r[CORNER_00] <= WW'(sfx) * WW'(sfy);
      wgt_r[CORNER_01] <= WW'(sfx) * WW'(fy_r);
      wgt_r[CORNER_10] <= WW'(fx_r) * WW'(sfy);
      wgt_r[CORNER_11] <= WW'(fx_r) * WW'(fy_r);
    end
  end

  // pixel store, single port
  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_r;
  logic [SIZE_W-1:0]  xs, ys;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_ok;

  always_comb begin
    case (cmd.rd_corner)
      CORNER_00: begin xs = x_r;  ys = y_r;  end
      CORNER_01: begin xs = x_r;  ys = y2_r; end
      CORNER_10: begin xs = x2_r; ys = y_r;  end
      CORNER_11: begin xs = x2_r; ys = y2_r; end
      default:   begin xs = x_r;  ys = y_r;  end
    endcase
    rd_addr = AW'(ys * MAX_WIDTH) + AW'(xs);
    wr_addr = AW'(in_pixel_y * MAX_WIDTH) + AW'(in_pixel_x);
    wr_ok   = ({{(LIM_W-PIX_COORD_W){1'b0}}, in_pixel_x} < MAXW_L) &&
              ({{(LIM_W-PIX_COORD_W){1'b0}}, in_pixel_y} < MAXH_L);
  end

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[wr_addr] <= in_pixel_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // per-channel accumulate, one texel a cycle
  logic [ACCW-1:0]   acc_r   [NUM_CHAN];
  logic [ACCW-1:0]   acc_nxt [NUM_CHAN];
  logic [WW-1:0]     wsel;
  logic [CHAN_W-1:0] out_r   [NUM_CHAN];
  logic              out_strobe_r;

  always_comb begin
    wsel = wgt_r[cmd.acc_corner];
    for (int k = 0; k < NUM_CHAN; k++) begin
      acc_nxt[k] = (cmd.acc_clear ? ACC_ROUND : acc_r[k]) +
                   ACCW'(rdata_r[k*CHAN_W +: CHAN_W]) * ACCW'(wsel);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      if (cmd.acc_en) begin
        acc_r[k] <= acc_nxt[k];
      end
      if (cmd.out_near) begin
        out_r[k] <= rdata_r[k*CHAN_W +: CHAN_W];
      end else if (cmd.out_bilin) begin
        out_r[k] <= acc_nxt[k][2*WEIGHT_BITS +: CHAN_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.out_near | cmd.out_bilin;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_red    = out_r[0];
  assign out_green  = out_r[1];
  assign out_blue   = out_r[2];
  assign out_alpha  = out_r[3];

endmodule
`default_nettype wire

// File: test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest/bilinear texture sampler. Random pixel
// writes and samples go through the start/busy command port under several
// image sizes, including the zero and oversized settings. Every result strobe
// is checked against colours predicted from a shadow copy of the pixel store.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsnb_pkg::*;

  localparam int MAX_W        = 64;
  localparam int MAX_H        = 64;
  localparam int WGT_BITS     = 8;
  localparam int WGT_ONE      = 1 << WGT_BITS;
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 120;

  typedef struct {
    logic                   action;
    logic [PIX_COORD_W-1:0] pixel_x;
    logic [PIX_COORD_W-1:0] pixel_y;
    logic [PIXEL_W-1:0]     pixel_value;
    logic [COORD_W-1:0]     u_coord;
    logic [COORD_W-1:0]     v_coord;
    logic                   sample_mode;
  } sampler_cmd_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgba_t;

  logic                   clk            = 1'b0;
  logic                   rst_n          = 1'b0;
  logic                   cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index      = CFG_IMAGE_WIDTH;
  logic [SIZE_W-1:0]      cfg_data       = '0;
  logic                   start          = 1'b0;
  logic                   busy;
  logic                   in_action      = ACT_WRITE;
  logic [PIX_COORD_W-1:0] in_pixel_x     = '0;
  logic [PIX_COORD_W-1:0] in_pixel_y     = '0;
  logic [PIXEL_W-1:0]     in_pixel_value = '0;
  logic [COORD_W-1:0]     in_u_coord     = '0;
  logic [COORD_W-1:0]     in_v_coord     = '0;
  logic                   in_sample_mode = MODE_NEAREST;
  logic                   out_strobe;
  logic [CHAN_W-1:0]      out_red;
  logic [CHAN_W-1:0]      out_green;
  logic [CHAN_W-1:0]      out_blue;
  logic [CHAN_W-1:0]      out_alpha;

  // shadow state
  logic [SIZE_W-1:0]  size_w_reg = SIZE_RESET;
  logic [SIZE_W-1:0]  size_h_reg = SIZE_RESET;
  logic [PIXEL_W-1:0] texel_mem [MAX_W*MAX_H];
  bit                 written_map [MAX_W*MAX_H];

  sampler_cmd_t cmd_fifo[$];
  rgba_t        colour_fifo[$];

  int  gap_cnt      = 0;
  bit  steady_feed  = 1'b0;
  int  err_count    = 0;
  int  n_writes     = 0;
  int  n_samples    = 0;
  int  n_bilinear   = 0;
  int  n_sizes      = 1;
  int  n_queued     = 0;

  texture_sampler_nearest_bilinear_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .WEIGHT_BITS(WGT_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_pixel_value(in_pixel_value),
    .in_u_coord    (in_u_coord),
    .in_v_coord    (in_v_coord),
    .in_sample_mode(in_sample_mode),
    .out_strobe    (out_strobe),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha)
  );

  always #5 clk = ~clk;

  // zero size acts as 1, oversize clamps to the store dimension
  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] raw, input int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return 32'(raw);
  endfunction

  // 2x2 footprint and weight fractions; nearest collapses to one texel, zero fraction
  function automatic void footprint(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                    input logic mode,
                                    output int unsigned x0, output int unsigned y0,
                                    output int unsigned x1, output int unsigned y1,
                                    output int unsigned fx, output int unsigned fy);
    int unsigned w, h, pu, pv;
    w  = clamp_size(size_w_reg, MAX_W);
    h  = clamp_size(size_h_reg, MAX_H);
    pu = u * w;
    pv = v * h;
    if (mode == MODE_NEAREST) begin
      x0 = ((pu + 32'h8000) >> COORD_W) % w;
      y0 = ((pv + 32'h8000) >> COORD_W) % h;
      x1 = x0;
      y1 = y0;
      fx = 0;
      fy = 0;
    end else begin
      x0 = (pu >> COORD_W) % w;
      y0 = (pv >> COORD_W) % h;
      x1 = (x0 + 1) % w;
      y1 = (y0 + 1) % h;
      fx = (pu >> (COORD_W - WGT_BITS)) & (WGT_ONE - 1);
      fy = (pv >> (COORD_W - WGT_BITS)) & (WGT_ONE - 1);
    end
  endfunction

  function automatic rgba_t filter_texels(input sampler_cmd_t c);
    int unsigned x0, y0, x1, y1, fx, fy;
    int unsigned w00, w01, w10, w11, acc;
    logic [PIXEL_W-1:0] c00, c01, c10, c11, packed_rgba;
    int ch;
    footprint(c.u_coord, c.v_coord, c.sample_mode, x0, y0, x1, y1, fx, fy);
    c00 = texel_mem[y0*MAX_W + x0];
    c01 = texel_mem[y1*MAX_W + x0];
    c10 = texel_mem[y0*MAX_W + x1];
    c11 = texel_mem[y1*MAX_W + x1];
    w00 = (WGT_ONE - fx) * (WGT_ONE - fy);
    w01 = (WGT_ONE - fx) * fy;
    w10 = fx * (WGT_ONE - fy);
    w11 = fx * fy;
    for (ch = 0; ch < NUM_CHAN; ch++) begin
      acc = c00[CHAN_W*ch +: CHAN_W] * w00 + c01[CHAN_W*ch +: CHAN_W] * w01
          + c10[CHAN_W*ch +: CHAN_W] * w10 + c11[CHAN_W*ch +: CHAN_W] * w11
          + (WGT_ONE * WGT_ONE) / 2;
      acc = acc >> (2 * WGT_BITS);
      if (acc > 255) acc = 255;
      packed_rgba[CHAN_W*ch +: CHAN_W] = acc[CHAN_W-1:0];
    end
    return rgba_t'(packed_rgba);
  endfunction

  // unused fields of each command still get random values
  function automatic sampler_cmd_t random_cmd();
    sampler_cmd_t c;
    c.action      = ($urandom_range(0, 1) == 0) ? ACT_WRITE : ACT_SAMPLE;
    c.pixel_x     = PIX_COORD_W'($urandom_range(0, MAX_W - 1));
    c.pixel_y     = PIX_COORD_W'($urandom_range(0, MAX_H - 1));
    c.pixel_value = $urandom;
    c.u_coord     = COORD_W'($urandom);
    c.v_coord     = COORD_W'($urandom);
    c.sample_mode = ($urandom_range(0, 1) == 0) ? MODE_NEAREST : MODE_BILINEAR;
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return COORD_W'(32'h8000 + $urandom_range(0, 8) - 4);
      3: return COORD_W'($urandom_range(0, 255));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic enqueue_cmd(input sampler_cmd_t c);
    cmd_fifo.insert(cmd_fifo.size(), c);
    n_queued++;
  endtask

  task automatic queue_write(input int unsigned x, input int unsigned y,
                             input logic [PIXEL_W-1:0] value);
    sampler_cmd_t c;
    c             = random_cmd();
    c.action      = ACT_WRITE;
    c.pixel_x     = PIX_COORD_W'(x);
    c.pixel_y     = PIX_COORD_W'(y);
    c.pixel_value = value;
    written_map[y*MAX_W + x] = 1'b1;
    enqueue_cmd(c);
  endtask

  // texels of the footprint that were never stored get a write first
  task automatic queue_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                              input logic mode);
    sampler_cmd_t c;
    int unsigned x0, y0, x1, y1, fx, fy;
    footprint(u, v, mode, x0, y0, x1, y1, fx, fy);
    if (!written_map[y0*MAX_W + x0]) queue_write(x0, y0, $urandom);
    if (!written_map[y1*MAX_W + x0]) queue_write(x0, y1, $urandom);
    if (!written_map[y0*MAX_W + x1]) queue_write(x1, y0, $urandom);
    if (!written_map[y1*MAX_W + x1]) queue_write(x1, y1, $urandom);
    c             = random_cmd();
    c.action      = ACT_SAMPLE;
    c.u_coord     = u;
    c.v_coord     = v;
    c.sample_mode = mode;
    enqueue_cmd(c);
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (cmd_fifo.size() != 0 || start || colour_fifo.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) size_w_reg = value;
    else size_h_reg = value;
  endtask

  // driver: predicts on each command transfer, then offers the next command
  always @(posedge clk) begin
    sampler_cmd_t c;
    logic xfer;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      xfer = start && !busy;
      if (xfer) begin
        c.action      = in_action;
        c.pixel_x     = in_pixel_x;
        c.pixel_y     = in_pixel_y;
        c.pixel_value = in_pixel_value;
        c.u_coord     = in_u_coord;
        c.v_coord     = in_v_coord;
        c.sample_mode = in_sample_mode;
        if (c.action == ACT_WRITE) begin
          texel_mem[{c.pixel_y, c.pixel_x}] = c.pixel_value;
          n_writes++;
        end else begin
          colour_fifo.insert(colour_fifo.size(), filter_texels(c));
          n_samples++;
          if (c.sample_mode == MODE_BILINEAR) n_bilinear++;
        end
        if (!steady_feed && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 17);
      end
      if (xfer || !start) begin
        if (gap_cnt != 0 && !steady_feed) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (cmd_fifo.size() != 0) begin
          c = cmd_fifo.pop_front();
          in_action      <= c.action;
          in_pixel_x     <= c.pixel_x;
          in_pixel_y     <= c.pixel_y;
          in_pixel_value <= c.pixel_value;
          in_u_coord     <= c.u_coord;
          in_v_coord     <= c.v_coord;
          in_sample_mode <= c.sample_mode;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_chan(input string name, input logic [CHAN_W-1:0] want,
                                     input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  // monitor: results cannot be held off, every strobe is a transfer
  always @(posedge clk) begin
    rgba_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (colour_fifo.size() == 0) begin
        $error("result strobe with no sample outstanding");
        err_count++;
      end else begin
        want = colour_fifo.pop_front();
        check_chan("red",   want.red,   out_red);
        check_chan("green", want.green, out_green);
        check_chan("blue",  want.blue,  out_blue);
        check_chan("alpha", want.alpha, out_alpha);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", colour_fifo.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [SIZE_W-1:0] phase_w [NUM_PHASES];
    logic [SIZE_W-1:0] phase_h [NUM_PHASES];
    int p;
    int phase_base;
    phase_w = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd65, 7'd17, 7'd64, 7'd0, 7'd0};
    phase_h = '{7'd64, 7'd1, 7'd0, 7'd100, 7'd5, 7'd64, 7'd64, 7'd2, 7'd0, 7'd0};
    phase_w[8] = SIZE_W'($urandom_range(1, 64));
    phase_h[8] = SIZE_W'($urandom_range(1, 64));
    phase_w[9] = SIZE_W'($urandom_range(0, 127));
    phase_h[9] = SIZE_W'($urandom_range(0, 127));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset size: corners, wrap of rounding, wrapped neighbours
    queue_write(0, 0, 32'h0000_0000);
    queue_write(MAX_W - 1, MAX_H - 1, 32'hFFFF_FFFF);
    queue_write(MAX_W - 1, 0, 32'h00FF_00FF);
    queue_write(0, MAX_H - 1, 32'hFF00_FF00);
    queue_sample(16'h0000, 16'h0000, MODE_NEAREST);
    queue_sample(16'hFFFF, 16'hFFFF, MODE_NEAREST);
    queue_sample(16'h8000, 16'h7FFF, MODE_NEAREST);
    queue_sample(16'hFFFF, 16'hFFFF, MODE_BILINEAR);
    queue_sample(16'h0000, 16'h0000, MODE_BILINEAR);
    queue_sample(16'h7FFF, 16'h0100, MODE_BILINEAR);
    wait_drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_size(CFG_IMAGE_WIDTH, phase_w[p]);
      write_size(CFG_IMAGE_HEIGHT, phase_h[p]);
      n_sizes++;
      if (p == NUM_PHASES - 1) steady_feed = 1'b1;
      @(negedge clk);
      // footprint fill writes count toward the phase budget
      phase_base = n_queued;
      while (n_queued - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0)
          queue_write($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1), $urandom);
        else
          queue_sample(pick_coord(), pick_coord(),
                       ($urandom_range(0, 1) == 0) ? MODE_NEAREST : MODE_BILINEAR);
      end
      wait_drain();
    end

    $display("Covered %0d pixel writes and %0d samples (%0d bilinear) over %0d size settings,",
             n_writes, n_samples, n_bilinear, n_sizes);
    $display("including zero and oversized dimensions and random sender gaps.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
